/* sv/prt_pkg.sv */
// Shared constants, types and codes for the priority sorted region table.
package prt_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = 64;
   localparam int PRIO_W = 8;
   localparam int PERM_W = 3;
   localparam int OCC_W = 4;
   localparam int STAT_W = 2;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE     = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NO_MATCH = 2'd2
   } op_status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic [PRIO_W-1:0] prio;
      logic [PERM_W-1:0] perm;
   } entry_type;

   typedef struct packed {
      logic          capture;
      logic          insert;
      logic          remove;
      logic          load;
      logic          set_status;
      op_status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       any_hit;
      logic       last;
   } dp_stat_type;

endpackage

/* sv/prt_ctrl.sv */
// Sequencer for the region table: update, then readout of the sorted table.
module prt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  prt_pkg::dp_stat_type   dp_stat,
   output prt_pkg::ctrl_cmd_type  cmd
);
   import prt_pkg::*;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      found_in   = found_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      cmd.status = STAT_DONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               found_in    = 1'b0;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (dp_stat.action == ACT_INSERT) begin
               cmd.set_status = 1'b1;
               if (dp_stat.full) begin
                  cmd.status = STAT_FULL;
               end else begin
                  cmd.insert = 1'b1;
               end
               state_in = ST_LOAD;
            end else if (dp_stat.any_hit) begin
               // one matching entry leaves per cycle
               cmd.remove = 1'b1;
               found_in   = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = found_ff ? STAT_DONE : STAT_NO_MATCH;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (dp_stat.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* sv/prt_dpath.sv */
// Region table storage with lane-wise insert and compaction, plus readout register.
module prt_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  prt_pkg::ctrl_cmd_type         cmd,
   input  logic                          req_action,
   input  logic [prt_pkg::ADDR_W-1:0]    req_entry_start,
   input  logic [prt_pkg::ADDR_W-1:0]    req_entry_end,
   input  logic [prt_pkg::PRIO_W-1:0]    req_entry_priority,
   input  logic [prt_pkg::PERM_W-1:0]    req_entry_permission,
   output prt_pkg::dp_stat_type          dp_stat,
   output logic [prt_pkg::STAT_W-1:0]    rsp_op_status,
   output logic                          rsp_slot_valid,
   output logic [prt_pkg::ADDR_W-1:0]    rsp_out_start,
   output logic [prt_pkg::ADDR_W-1:0]    rsp_out_end,
   output logic [prt_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [prt_pkg::PERM_W-1:0]    rsp_out_permission,
   output logic [prt_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                          rsp_last_of_run
);
   import prt_pkg::*;

   entry_type            tbl_ff [TABLE_DEPTH];
   entry_type            ins_in [TABLE_DEPTH];
   entry_type            del_in [TABLE_DEPTH];
   logic [CNT_W-1:0]     count_ff;
   entry_type            req_ff;
   action_type           action_ff;
   logic [IDX_W-1:0]     ptr_ff;
   op_status_type        status_ff;

   logic [TABLE_DEPTH-1:0] lane_valid, lane_le, lane_hit, lane_shift;
   logic                   full;
   entry_type              rd_entry;
   logic                   rd_last;

   op_status_type     rsp_status_ff;
   logic              rsp_slot_ff;
   entry_type         rsp_entry_ff;
   logic [OCC_W-1:0]  rsp_occ_ff;
   logic              rsp_last_ff;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         lane_valid[i] = CNT_W'(i) < count_ff;
         lane_le[i]    = lane_valid[i] && (tbl_ff[i].prio <= req_ff.prio);
         lane_hit[i]   = lane_valid[i] && (tbl_ff[i] == req_ff);
      end
      // lanes at or above the first hit pull from the lane above
      lane_shift[0] = lane_hit[0];
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         lane_shift[i] = lane_shift[i-1] | lane_hit[i];
      end
      // entries of lower or equal priority stay; new one lands just past them
      ins_in[0] = lane_le[0] ? tbl_ff[0] : req_ff;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         if (lane_le[i]) begin
            ins_in[i] = tbl_ff[i];
         end else if (lane_le[i-1]) begin
            ins_in[i] = req_ff;
         end else begin
            ins_in[i] = tbl_ff[i-1];
         end
      end
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
         del_in[i] = lane_shift[i] ? tbl_ff[i+1] : tbl_ff[i];
      end
      del_in[TABLE_DEPTH-1] = tbl_ff[TABLE_DEPTH-1];
   end

   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_entry = tbl_ff[ptr_ff];
   assign rd_last  = (CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         tbl_ff <= ins_in;
      end else if (cmd.remove) begin
         tbl_ff <= del_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (cmd.insert) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.remove) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.capture) begin
            ptr_ff <= '0;
         end else if (cmd.load) begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff         <= action_type'(req_action);
         req_ff.start_addr <= req_entry_start;
         req_ff.end_addr   <= req_entry_end;
         req_ff.prio       <= req_entry_priority;
         req_ff.perm       <= req_entry_permission;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
         if (count_ff == '0) begin
            rsp_slot_ff  <= 1'b0;
            rsp_entry_ff <= '0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_slot_ff  <= 1'b1;
            rsp_entry_ff <= rd_entry;
            rsp_last_ff  <= rd_last;
         end
      end
   end

   assign dp_stat.action  = action_ff;
   assign dp_stat.full    = full;
   assign dp_stat.any_hit = |lane_hit;
   assign dp_stat.last    = rsp_last_ff;

   assign rsp_op_status      = rsp_status_ff;
   assign rsp_slot_valid     = rsp_slot_ff;
   assign rsp_out_start      = rsp_entry_ff.start_addr;
   assign rsp_out_end        = rsp_entry_ff.end_addr;
   assign rsp_out_priority   = rsp_entry_ff.prio;
   assign rsp_out_permission = rsp_entry_ff.perm;
   assign rsp_occupancy      = rsp_occ_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !full)
      else $error("insert into a full table");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add one entry");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete step did not drop one entry");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (rsp_slot_ff || rsp_last_ff))
      else $error("empty readout not flagged last");

endmodule

/* sv/priority_sorted_region_table.sv */
// Top level of the priority sorted region table: controller plus datapath.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    action, entry start/end/priority/permission
//   rsp      rsp_valid/rsp_ready    status, slot valid, entry fields, occupancy, last
//
// Insert: adds the entry in the update state. Delete: removes matching entries, then sets status.
// Readout: a load state, then one result per cycle while rsp_ready is high;
// occupancy results (one if empty) per request.
// One request at a time; req_ready is high only between requests.
// Synchronous reset empties the table; rsp stalls simply hold the result.
module priority_sorted_region_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [prt_pkg::ADDR_W-1:0]    req_entry_start,
   input  logic [prt_pkg::ADDR_W-1:0]    req_entry_end,
   input  logic [prt_pkg::PRIO_W-1:0]    req_entry_priority,
   input  logic [prt_pkg::PERM_W-1:0]    req_entry_permission,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [prt_pkg::STAT_W-1:0]    rsp_op_status,
   output logic                          rsp_slot_valid,
   output logic [prt_pkg::ADDR_W-1:0]    rsp_out_start,
   output logic [prt_pkg::ADDR_W-1:0]    rsp_out_end,
   output logic [prt_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [prt_pkg::PERM_W-1:0]    rsp_out_permission,
   output logic [prt_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                          rsp_last_of_run
);
   import prt_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  dp_stat;

   prt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   prt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_action           (req_action),
      .req_entry_start      (req_entry_start),
      .req_entry_end        (req_entry_end),
      .req_entry_priority   (req_entry_priority),
      .req_entry_permission (req_entry_permission),
      .dp_stat              (dp_stat),
      .rsp_op_status        (rsp_op_status),
      .rsp_slot_valid       (rsp_slot_valid),
      .rsp_out_start        (rsp_out_start),
      .rsp_out_end          (rsp_out_end),
      .rsp_out_priority     (rsp_out_priority),
      .rsp_out_permission   (rsp_out_permission),
      .rsp_occupancy        (rsp_occupancy),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule
